@@ src/tpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

  // Width and reset value of the determinant threshold register
  localparam int EPS_BITS = 31;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 31'd1;

  // Status that travels with each result word
  typedef struct packed {
    logic saturated;
    logic found;
  } tpi_flags_t;

endpackage

`default_nettype wire

@@ src/tpi_cross.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpi_cross #(
  parameter int W = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  signed [W-1:0]      col_x [3],
  input  wire  signed [W-1:0]      col_y [3],
  input  wire  signed [W-1:0]      col_z [3],
  input  wire  signed [W-1:0]      offs  [3],
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [W-1:0]      px    [3],
  output logic signed [W-1:0]      py    [3],
  output logic signed [W-1:0]      pz    [3],
  output logic signed [W-1:0]      pd    [3],
  output logic signed [2*W:0]      u     [3],
  output logic signed [2*W:0]      v     [3]
);

  localparam int C = 2 * W + 1;

  logic en;
  logic va;
  logic vb;

  logic signed [2*W-1:0] pu_a [3];
  logic signed [2*W-1:0] pu_b [3];
  logic signed [2*W-1:0] pv_a [3];
  logic signed [2*W-1:0] pv_b [3];
  logic signed [W-1:0]   a_x  [3];
  logic signed [W-1:0]   a_y  [3];
  logic signed [W-1:0]   a_z  [3];
  logic signed [W-1:0]   a_d  [3];

  // Advance the whole chain unless the last word is stuck
  assign en        = ~vb | out_ready;
  assign in_ready  = en;
  assign out_valid = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    // Products first, then the cross differences
    always_ff @(posedge clk) begin
      if (en) begin
        pu_a[i] <= col_y[J] * col_z[K];
        pu_b[i] <= col_y[K] * col_z[J];
        pv_a[i] <= col_x[J] * offs[K];
        pv_b[i] <= col_x[K] * offs[J];
        a_x[i]  <= col_x[i];
        a_y[i]  <= col_y[i];
        a_z[i]  <= col_z[i];
        a_d[i]  <= offs[i];
        u[i]    <= C'(pu_a[i]) - C'(pu_b[i]);
        v[i]    <= C'(pv_a[i]) - C'(pv_b[i]);
        px[i]   <= a_x[i];
        py[i]   <= a_y[i];
        pz[i]   <= a_z[i];
        pd[i]   <= a_d[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ src/tpi_dot.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpi_dot #(
  parameter int W = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  signed [W-1:0]      col_x [3],
  input  wire  signed [W-1:0]      col_y [3],
  input  wire  signed [W-1:0]      col_z [3],
  input  wire  signed [W-1:0]      offs  [3],
  input  wire  signed [2*W:0]      u     [3],
  input  wire  signed [2*W:0]      v     [3],
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [3*W+2:0]    det,
  output logic signed [3*W+2:0]    num_x,
  output logic signed [3*W+2:0]    num_y,
  output logic signed [3*W+2:0]    num_z
);

  localparam int C  = 2 * W + 1;
  localparam int T  = 3 * W + 1;
  localparam int DW = 3 * W + 3;

  logic en;
  logic va;
  logic vb;
  logic vc;

  logic signed [W-1:0]   op_a [4][3];
  logic signed [C-1:0]   op_c [4][3];
  logic signed [2*W:0]   lo   [4][3];
  logic signed [2*W:0]   hi   [4][3];
  logic signed [T-1:0]   term [4][3];
  logic signed [DW-1:0]  dot  [4];

  assign en        = ~vc | out_ready;
  assign in_ready  = en;
  assign out_valid = vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  // Lane 0: determinant, lanes 1 to 3: numerators of x, y and (negated) z
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[0][i] = col_x[i];
      op_c[0][i] = u[i];
      op_a[1][i] = offs[i];
      op_c[1][i] = u[i];
      op_a[2][i] = col_z[i];
      op_c[2][i] = v[i];
      op_a[3][i] = col_y[i];
      op_c[3][i] = v[i];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_term
      logic signed [W:0] c_lo;
      logic signed [W:0] c_hi;

      // Split the wide cross term into an unsigned low half and a signed high half
      assign c_lo = $signed({1'b0, op_c[l][i][W-1:0]});
      assign c_hi = op_c[l][i][C-1:W];

      always_ff @(posedge clk) begin
        if (en) begin
          lo[l][i]   <= op_a[l][i] * c_lo;
          hi[l][i]   <= op_a[l][i] * c_hi;
          term[l][i] <= (T'(hi[l][i]) <<< W) + T'(lo[l][i]);
        end
      end
    end

    // Sum the three terms
    always_ff @(posedge clk) begin
      if (en) begin
        dot[l] <= DW'(term[l][0]) + DW'(term[l][1]) + DW'(term[l][2]);
      end
    end
  end

  assign det   = dot[0];
  assign num_x = dot[1];
  assign num_y = dot[2];
  assign num_z = dot[3];

endmodule

`default_nettype wire

@@ src/tpi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpi_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  signed [3*W+2:0]            det,
  input  wire  signed [3*W+2:0]            num_x,
  input  wire  signed [3*W+2:0]            num_y,
  input  wire  signed [3*W+2:0]            num_z,
  input  wire  [tpi_pkg::EPS_BITS-1:0]     eps,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [W-1:0]              point [3],
  output tpi_pkg::tpi_flags_t              flags
);

  localparam int DW = 3 * W + 3;
  localparam int RW = DW + W + F + 3;
  localparam int NS = W + 4;

  logic en;
  logic vs [NS];

  logic signed [DW-1:0] nm [3];
  logic                 num_neg [3];

  // Stage 1: magnitudes and signs
  logic [DW-1:0] s1_ad;
  logic [DW-1:0] s1_an [3];
  logic          s1_neg [3];
  logic          s1_detz;

  // Stage 2: scaled numerators, divisor, threshold test
  logic [RW-1:0] s2_n2 [3];
  logic [RW-1:0] s2_dd;
  logic          s2_neg [3];
  logic          s2_nf;

  // Divider chain, index 0 is the range check stage
  logic [RW-1:0] rem  [W+1][3];
  logic [W-1:0]  quo  [W+1][3];
  logic          ovf  [W+1][3];
  logic          sgn  [W+1][3];
  logic [RW-1:0] dd   [W+1];
  logic          nf   [W+1];

  logic          sat  [3];

  assign en        = ~vs[NS-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = vs[NS-1];

  // Advance valid bits along the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vs[k] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
      for (int k = 1; k < NS; k++) vs[k] <= vs[k-1];
    end
  end

  assign nm[0]      = num_x;
  assign nm[1]      = num_y;
  assign nm[2]      = num_z;
  assign num_neg[0] = num_x[DW-1];
  assign num_neg[1] = num_y[DW-1];
  // z numerator is negated; its sign only matters when it is nonzero
  assign num_neg[2] = ~num_z[DW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad   <= det[DW-1] ? DW'(-det) : DW'(det);
      s1_detz <= (det == '0);
      for (int l = 0; l < 3; l++) begin
        s1_an[l]  <= nm[l][DW-1] ? DW'(-nm[l]) : DW'(nm[l]);
        s1_neg[l] <= num_neg[l] ^ det[DW-1];
      end
    end
  end

  // Form 2*|num|*2^F + |det| over 2*|det| for round-half-away; test |det| against eps
  always_ff @(posedge clk) begin
    if (en) begin
      s2_nf <= s1_detz | (RW'(s1_ad) < (RW'(eps) << (2 * F)));
      s2_dd <= RW'(s1_ad) << 1;
      for (int l = 0; l < 3; l++) begin
        s2_n2[l]  <= (RW'(s1_an[l]) << (F + 1)) + RW'(s1_ad);
        s2_neg[l] <= s1_neg[l];
      end
    end
  end

  // Flag quotients that do not fit in W bits
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= s2_dd;
      nf[0] <= s2_nf;
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= s2_n2[l];
        quo[0][l] <= '0;
        ovf[0][l] <= (s2_n2[l] >= (s2_dd << W));
        sgn[0][l] <= s2_neg[l];
      end
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < W; s++) begin : g_step
    localparam int B = W - 1 - s;
    logic [RW-1:0] trial;

    assign trial = dd[s] << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dd[s+1] <= dd[s];
        nf[s+1] <= nf[s];
        for (int l = 0; l < 3; l++) begin
          ovf[s+1][l] <= ovf[s][l];
          sgn[s+1][l] <= sgn[s][l];
          if (rem[s][l] >= trial) begin
            rem[s+1][l] <= rem[s][l] - trial;
            quo[s+1][l] <= quo[s][l] | (W'(1) << B);
          end else begin
            rem[s+1][l] <= rem[s][l];
            quo[s+1][l] <= quo[s][l];
          end
        end
      end
    end
  end

  // Clamp against the limit of the result's sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sat[l] = ovf[W][l] | (sgn[W][l] ? (quo[W][l][W-1] & (|quo[W][l][W-2:0]))
                                      : quo[W][l][W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (nf[W]) begin
          point[l] <= '0;
        end else if (sat[l]) begin
          point[l] <= sgn[W][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          point[l] <= sgn[W][l] ? -quo[W][l] : quo[W][l];
        end
      end
      flags.found     <= ~nf[W];
      flags.saturated <= ~nf[W] & (sat[0] | sat[1] | sat[2]);
    end
  end

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flags.found |->
      point[0] == '0 && point[1] == '0 && point[2] == '0 && !flags.saturated)
    else $error("result without a point is not cleared");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    vs[1] && !s2_nf |-> s2_dd != '0)
    else $error("division started with a zero divisor");
`endif

endmodule

`default_nettype wire

@@ src/three_plane_intersection_point_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Intersection point of three planes in signed fixed point (FRAC_BITS fraction
// bits, WORD_BITS wide). Each input word carries the three planes as normal and
// offset; each result word carries the point, found and saturated. The unit is
// fully pipelined and takes one word per clock unless the output stalls. The
// restoring divider spends one stage per quotient bit after two cross-product
// stages, three dot-product stages and three stages of sign, scaling and range
// check. A stall at the output holds the whole pipeline without losing words.
// The det_epsilon register must be written through the cfg port only while the
// unit is idle (the unit does not enforce this); it resets to one LSB. When
// |det| is below det_epsilon scaled to the determinant's format, or det is
// zero, found is 0 and the point is zero. Coordinates are rounded to nearest
// with ties away from zero and clamped to the word range.
module three_plane_intersection_point_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // plane1_nx, plane1_ny, plane1_nz, plane1_offset, plane2_nx, plane2_ny,
  // plane2_nz, plane2_offset, plane3_nx, plane3_ny, plane3_nz, plane3_offset
  input  wire  [((12*WORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y, point_z
  output logic [((3*WORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // found, saturated
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  input  wire  [tpi_pkg::EPS_BITS-1:0]         cfg_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready
);

  localparam int W       = WORD_BITS;
  localparam int OUT_BITS = ((3 * W + 7) / 8) * 8;

  logic [tpi_pkg::EPS_BITS-1:0] det_epsilon;

  logic signed [W-1:0] col_x [3];
  logic signed [W-1:0] col_y [3];
  logic signed [W-1:0] col_z [3];
  logic signed [W-1:0] offs  [3];

  logic                cr_valid;
  logic                cr_ready;
  logic signed [W-1:0] cr_x [3];
  logic signed [W-1:0] cr_y [3];
  logic signed [W-1:0] cr_z [3];
  logic signed [W-1:0] cr_d [3];
  logic signed [2*W:0] cr_u [3];
  logic signed [2*W:0] cr_v [3];

  logic                  dt_valid;
  logic                  dt_ready;
  logic signed [3*W+2:0] dt_det;
  logic signed [3*W+2:0] dt_nx;
  logic signed [3*W+2:0] dt_ny;
  logic signed [3*W+2:0] dt_nz;

  logic signed [W-1:0]  point [3];
  tpi_pkg::tpi_flags_t  flags;

  // Threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= tpi_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      det_epsilon <= cfg_data;
    end
  end

  // Unpack the three planes into matrix columns
  for (genvar p = 0; p < 3; p++) begin : g_plane
    assign col_x[p] = s_axis_tdata[(4*p+0)*W +: W];
    assign col_y[p] = s_axis_tdata[(4*p+1)*W +: W];
    assign col_z[p] = s_axis_tdata[(4*p+2)*W +: W];
    assign offs[p]  = s_axis_tdata[(4*p+3)*W +: W];
  end

  tpi_cross #(.W(W)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .col_x     (col_x),
    .col_y     (col_y),
    .col_z     (col_z),
    .offs      (offs),
    .out_valid (cr_valid),
    .out_ready (cr_ready),
    .px        (cr_x),
    .py        (cr_y),
    .pz        (cr_z),
    .pd        (cr_d),
    .u         (cr_u),
    .v         (cr_v)
  );

  tpi_dot #(.W(W)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_valid),
    .in_ready  (cr_ready),
    .col_x     (cr_x),
    .col_y     (cr_y),
    .col_z     (cr_z),
    .offs      (cr_d),
    .u         (cr_u),
    .v         (cr_v),
    .out_valid (dt_valid),
    .out_ready (dt_ready),
    .det       (dt_det),
    .num_x     (dt_nx),
    .num_y     (dt_ny),
    .num_z     (dt_nz)
  );

  tpi_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dt_valid),
    .in_ready  (dt_ready),
    .det       (dt_det),
    .num_x     (dt_nx),
    .num_y     (dt_ny),
    .num_z     (dt_nz),
    .eps       (det_epsilon),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .point     (point),
    .flags     (flags)
  );

  // Pack the result word
  assign m_axis_tdata = OUT_BITS'({point[2], point[1], point[0]});
  assign m_axis_tuser = {flags.saturated, flags.found};

endmodule

`default_nettype wire

@@ dv/three_plane_intersection_point_unit_tb.sv @@
`timescale 1ns / 1ps

module three_plane_intersection_point_unit_tb;

  localparam int FRAC = 16;
  localparam int WB = 32;
  localparam int LATENCY = WB + 9;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  typedef logic [12*WB-1:0] planes_t;

  typedef struct packed {
    logic [WB-1:0] px;
    logic [WB-1:0] py;
    logic [WB-1:0] pz;
    logic          found;
    logic          saturated;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [12*WB-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [3*WB-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tpi_pkg::EPS_BITS-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  planes_t pending_planes[$];
  point_t expected_points[$];
  logic [tpi_pkg::EPS_BITS-1:0] threshold = tpi_pkg::EPS_RESET;
  int mismatches = 0;
  bit calm = 1'b0;
  bit word_taken = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  three_plane_intersection_point_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always #5 clk = ~clk;

  // Round num * 2^FRAC / det to nearest, ties away from zero, and clamp
  function automatic logic [WB-1:0] solve_coord(input logic signed [191:0] num,
                                                input logic signed [191:0] det,
                                                inout logic sat);
    logic neg;
    logic [191:0] an, ad, q, lim, mag;
    neg = (num < 0) != (det < 0);
    an = (num < 0) ? -num : num;
    ad = (det < 0) ? -det : det;
    q = ((an << (FRAC + 1)) + ad) / (ad << 1);
    lim = neg ? (192'd1 << (WB - 1)) : ((192'd1 << (WB - 1)) - 1);
    mag = q;
    if (q > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? WB'(-mag) : WB'(mag);
  endfunction

  // Cramer's rule on the normal matrix, all in exact wide integers
  function automatic point_t predict_point(input planes_t w,
                                           input logic [tpi_pkg::EPS_BITS-1:0] eps);
    logic signed [191:0] m1[3], m2[3], m3[3], d[3], u[3], v[3];
    logic signed [191:0] det, lim, adet;
    point_t r;
    logic sat;
    for (int i = 0; i < 3; i++) begin
      m1[i] = $signed(w[(i*4+0)*WB +: WB]);
      m2[i] = $signed(w[(i*4+1)*WB +: WB]);
      m3[i] = $signed(w[(i*4+2)*WB +: WB]);
      d[i]  = $signed(w[(i*4+3)*WB +: WB]);
    end
    u[0] = m2[1]*m3[2] - m2[2]*m3[1];
    u[1] = m2[2]*m3[0] - m2[0]*m3[2];
    u[2] = m2[0]*m3[1] - m2[1]*m3[0];
    det = m1[0]*u[0] + m1[1]*u[1] + m1[2]*u[2];
    lim = $signed({161'd0, eps}) <<< (2*FRAC);
    adet = (det < 0) ? -det : det;
    r = '0;
    if (det == 0 || adet < lim) return r;
    v[0] = m1[1]*d[2] - m1[2]*d[1];
    v[1] = m1[2]*d[0] - m1[0]*d[2];
    v[2] = m1[0]*d[1] - m1[1]*d[0];
    sat = 1'b0;
    r.px = solve_coord(d[0]*u[0] + d[1]*u[1] + d[2]*u[2], det, sat);
    r.py = solve_coord(m3[0]*v[0] + m3[1]*v[1] + m3[2]*v[2], det, sat);
    r.pz = solve_coord(-(m2[0]*v[0] + m2[1]*v[1] + m2[2]*v[2]), det, sat);
    r.found = 1'b1;
    r.saturated = sat;
    return r;
  endfunction

  function automatic planes_t planes(input logic [WB-1:0] a0, a1, a2, a3,
                                     b0, b1, b2, b3, c0, c1, c2, c3);
    return {c3, c2, c1, c0, b3, b2, b1, b0, a3, a2, a1, a0};
  endfunction

  function automatic logic [WB-1:0] rand_word(input int mode);
    logic [WB-1:0] x;
    case (mode)
      0: x = $urandom;
      1: x = WB'($signed($urandom_range(0, 16*65536)) - 8*65536);
      2: x = WB'($signed($urandom_range(0, 512)) - 256) << 16;
      default: x = WB'($signed($urandom_range(0, 64)) - 32);
    endcase
    return x;
  endfunction

  function automatic planes_t rand_planes();
    planes_t w;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) w[i*WB +: WB] = rand_word(mode);
    // copy the normal of plane 1 into plane 3 now and then for a singular matrix
    if ($urandom_range(0, 9) == 0) begin
      w[8*WB +: 3*WB] = w[0 +: 3*WB];
    end
    return w;
  endfunction

  // Append an input word to the pending queue
  task automatic queue_planes(input planes_t w);
    pending_planes.insert(pending_planes.size(), w);
  endtask

  task automatic write_threshold(input logic [tpi_pkg::EPS_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    threshold = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_planes.size() > 0 || expected_points.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Take input words and predict; check result words
  always @(posedge clk) begin
    point_t got, exp_pt;
    word_taken = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_points.insert(expected_points.size(),
                             predict_point(pending_planes.pop_front(), threshold));
      word_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[0 +: WB];
      got.py = m_axis_tdata[WB +: WB];
      got.pz = m_axis_tdata[2*WB +: WB];
      got.found = m_axis_tuser[0];
      got.saturated = m_axis_tuser[1];
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_pt = expected_points.pop_front();
        if (got !== exp_pt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h f=%b s=%b  got x=%h y=%h z=%h f=%b s=%b",
                     exp_pt.px, exp_pt.py, exp_pt.pz, exp_pt.found, exp_pt.saturated,
                     got.px, got.py, got.pz, got.found, got.saturated);
        end
      end
    end
  end

  // Drive input words; hold valid until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !word_taken) begin
        // hold current word
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_planes.size() > 0) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap = $urandom_range(0, 5);
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_planes[0];
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      // Stall the result side in bursts
      if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        recv_gap = $urandom_range(0, 5);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [tpi_pkg::EPS_BITS-1:0] eps_list[6];
    eps_list = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd3, 31'd1, 31'd0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: singular, identity, ties, extremes, saturation
    queue_planes('0);
    queue_planes(planes(ONE, 0, 0, 32'h0003_8000, 0, ONE, 0, 32'hFFFF_0001,
                        0, 0, ONE, MAXV));
    queue_planes(planes(ONE << 1, 0, 0, 32'd1, 0, ONE, 0, 32'd3,
                        0, 0, ONE, MINV));
    queue_planes(planes(ONE << 1, 0, 0, 32'hFFFF_FFFF, 0, ONE << 1, 0,
                        32'hFFFF_FFFD, 0, 0, ONE << 1, 32'd5));
    queue_planes(planes(MAXV, 0, 0, MAXV, 0, MAXV, 0, MINV, 0, 0, MAXV, 0));
    queue_planes(planes(MINV, 0, 0, MAXV, 0, MINV, 0, MINV, 0, 0, MINV, 1));
    queue_planes(planes(32'd1, 0, 0, MAXV, 0, 32'd1, 0, MINV, 0, 0, 32'd1, MAXV));
    queue_planes(planes(32'd256, 0, 0, ONE, 0, 32'd256, 0, ONE, 0, 0,
                        32'd256, ONE));
    queue_planes(planes(32'd255, 0, 0, ONE, 0, 32'd256, 0, ONE, 0, 0,
                        32'd256, ONE));
    queue_planes({12{MAXV}});
    queue_planes({12{MINV}});
    queue_planes(planes(MAXV, MINV, MAXV, MINV, MINV, MAXV, MAXV, MAXV,
                        MAXV, MAXV, MINV, MINV));
    queue_planes(planes(0, ONE, 0, 32'd7, ONE, 0, 0, 32'd9, 0, 0,
                        32'hFFFF_0000, 32'd11));
    drain();

    // Phases over several thresholds
    for (int p = 0; p < 6; p++) begin
      write_threshold(p == 5 ? threshold : eps_list[p]);
      if (p == 3) write_threshold(31'($urandom));
      if (p == 5) calm = 1'b1;
      queue_planes(planes(32'd256, 0, 0, ONE, 0, 32'd256, 0, ONE, 0, 0,
                          32'd256, ONE));
      for (int i = 0; i < 200; i++) queue_planes(rand_planes());
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tpi_pkg.sv
src/tpi_cross.sv
src/tpi_dot.sv
src/tpi_div.sv
src/three_plane_intersection_point_unit.sv
dv/three_plane_intersection_point_unit_tb.sv
